// ----- rtl/dkw_pkg.sv -----
// dkw_pkg: shared constants, status codes and controller/datapath signal groups
// for the k-window minimum span block; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package dkw_pkg;

  // default store depth
  localparam int CAPACITY_DEF = 1024;

  // fixed field widths
  localparam int VALUE_W = 32;
  localparam int WC_W    = 11;
  localparam int STAT_W  = 2;
  localparam int CNT_OUT_W = 11;

  // sign flip so that unsigned order equals signed order
  localparam logic [VALUE_W-1:0] SIGN_BIAS = 32'h8000_0000;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture input transaction, start search
    logic srch;      // linear search step
    logic up;        // open a slot and insert
    logic dn;        // close a slot
    logic span_init; // prepare window pass
    logic span;      // window pass step
    logic out_load;  // load result register
  } dkw_ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic srch_done;
    logic need_up;
    logic need_dn;
    logic up_done;
    logic dn_done;
    logic span_done;
  } dkw_stat_t;

endpackage
`default_nettype wire

// ----- rtl/dkw_if.sv -----
// dkw_if: valid/ready channel interfaces for input, result and configuration
// depends on dkw_pkg
`timescale 1ns / 1ps
`default_nettype none
interface dkw_in_if;
  import dkw_pkg::*;
  logic               valid;
  logic               ready;
  logic               command;
  logic [VALUE_W-1:0] value;
  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface dkw_out_if;
  import dkw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [VALUE_W-1:0]   span;
  logic                 found;
  logic [STAT_W-1:0]    status;
  logic [CNT_OUT_W-1:0] stored_count;
  modport source (output valid, span, found, status, stored_count, input ready);
  modport sink   (input valid, span, found, status, stored_count, output ready);
endinterface

interface dkw_cfg_if;
  import dkw_pkg::*;
  logic            valid;
  logic            ready;
  logic [WC_W-1:0] window_count;
  modport source (output valid, window_count, input ready);
  modport sink   (input valid, window_count, output ready);
endinterface
`default_nettype wire

// ----- rtl/dynamic_k_window_min_span.sv -----
// dynamic_k_window_min_span: top level joining controller and datapath
// depends on dkw_pkg, dkw_if, dkw_ctrl, dkw_dp
//
// channel  | dir | payload                                   | transaction
// in_ch    | in  | command, value                            | one insert or remove
// out_ch   | out | span, found, status, stored_count         | one result per item
// cfg_ch   | in  | window_count                              | always ready
//
// each item goes through a linear search, a one-entry-per-cycle shift in the
// store memory when a member is inserted or removed, then one window pass
// that reads two store entries per cycle.
// reset is synchronous active low; store contents need no clearing.
// a new item is taken while the previous result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module dynamic_k_window_min_span #(
  parameter int CAPACITY = dkw_pkg::CAPACITY_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  dkw_in_if.sink   in_ch,
  dkw_out_if.source out_ch,
  dkw_cfg_if.sink  cfg_ch
);
  import dkw_pkg::*;

  dkw_ctrl_t ctrl;
  dkw_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  dkw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .ctrl     (ctrl),
    .stat     (stat)
  );

  dkw_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .stat            (stat),
    .in_command      (in_ch.command),
    .in_value        (in_ch.value),
    .cfg_we          (cfg_ch.valid),
    .cfg_window_count(cfg_ch.window_count),
    .out_span        (out_ch.span),
    .out_found       (out_ch.found),
    .out_status      (out_ch.status),
    .out_stored_count(out_ch.stored_count)
  );

endmodule
`default_nettype wire

// ----- rtl/dkw_ctrl.sv -----
// dkw_ctrl: sequencing state machine for search, shift, window pass and output
// depends on dkw_pkg
`timescale 1ns / 1ps
`default_nettype none
module dkw_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dkw_pkg::dkw_ctrl_t     ctrl,
  input  wire dkw_pkg::dkw_stat_t stat
);
  import dkw_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_UP     = 7'b0000100,
    S_DN     = 7'b0001000,
    S_SPINIT = 7'b0010000,
    S_SPAN   = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.load = 1'b1;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        ctrl.srch = 1'b1;
        if (stat.srch_done) begin
          if (stat.need_up) state_nxt = S_UP;
          else if (stat.need_dn) state_nxt = S_DN;
          else state_nxt = S_SPINIT;
        end
      end
      S_UP: begin
        ctrl.up = 1'b1;
        if (stat.up_done) state_nxt = S_SPINIT;
      end
      S_DN: begin
        ctrl.dn = 1'b1;
        if (stat.dn_done) state_nxt = S_SPINIT;
      end
      S_SPINIT: begin
        ctrl.span_init = 1'b1;
        state_nxt      = S_SPAN;
      end
      S_SPAN: begin
        ctrl.span = 1'b1;
        if (stat.span_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          ctrl.out_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (ctrl.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dkw_dp.sv -----
// dkw_dp: sorted store memory, counters, window minimum and result register
// depends on dkw_pkg
`timescale 1ns / 1ps
`default_nettype none
module dkw_dp #(
  parameter int CAPACITY = dkw_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dkw_pkg::dkw_ctrl_t            ctrl,
  output dkw_pkg::dkw_stat_t                 stat,
  input  wire logic                          in_command,
  input  wire logic [dkw_pkg::VALUE_W-1:0]   in_value,
  input  wire logic                          cfg_we,
  input  wire logic [dkw_pkg::WC_W-1:0]      cfg_window_count,
  output logic [dkw_pkg::VALUE_W-1:0]        out_span,
  output logic                               out_found,
  output logic [dkw_pkg::STAT_W-1:0]         out_status,
  output logic [dkw_pkg::CNT_OUT_W-1:0]      out_stored_count
);
  import dkw_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > WC_W) ? CW : WC_W;

  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rdata_a_r, rdata_b_r;
  logic [AW-1:0]      raddr_a, raddr_b, waddr;
  logic               we;
  logic [VALUE_W-1:0] wdata;

  logic [VALUE_W-1:0] key_r;
  logic               cmd_r;
  logic [CW-1:0]      count_r;
  logic [WC_W-1:0]    wc_r;
  logic [CW-1:0]      pos_r;
  logic [STAT_W-1:0]  status_r;
  logic [VALUE_W-1:0] span_r;
  logic               found_r;
  logic [IW-1:0]      i_r, q_r;
  logic               v_r;

  logic [IW-1:0]      kx, cnt_x, pos_x, pos_c;
  logic               hit, present_c, full_c, more_up, more_dn, more_span;
  logic [VALUE_W-1:0] diff;

  // derived window size and extended counts
  assign kx    = (wc_r == '0) ? IW'(1) : IW'(wc_r);
  assign cnt_x = IW'(count_r);
  assign pos_x = IW'(pos_r);

  // search compare on the returned entry
  assign hit       = v_r && (rdata_a_r >= key_r);
  assign present_c = hit && (rdata_a_r == key_r);
  assign pos_c     = hit ? q_r : cnt_x;
  assign full_c    = (cnt_x >= IW'(CAPACITY));

  assign more_up   = (i_r > pos_x);
  assign more_dn   = ((i_r + IW'(1)) < cnt_x);
  assign more_span = (i_r < cnt_x);
  assign diff      = rdata_a_r - rdata_b_r;

  // status toward the controller
  always_comb begin
    stat.srch_done = ctrl.srch && (hit || (i_r == cnt_x));
    stat.need_up   = (cmd_r == CMD_INSERT) && !present_c && !full_c;
    stat.need_dn   = (cmd_r == CMD_REMOVE) && present_c;
    stat.up_done   = ctrl.up && !more_up && !v_r;
    stat.dn_done   = ctrl.dn && !more_dn && !v_r;
    stat.span_done = ctrl.span && !more_span && !v_r;
  end

  // memory address and write selection
  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    we      = 1'b0;
    waddr   = q_r[AW-1:0];
    wdata   = rdata_a_r;
    if (ctrl.srch) raddr_a = i_r[AW-1:0];
    if (ctrl.up) begin
      raddr_a = AW'(i_r - IW'(1));
      if (v_r) begin
        we = 1'b1;
      end else if (!more_up) begin
        we    = 1'b1;
        waddr = pos_r[AW-1:0];
        wdata = key_r;
      end
    end
    if (ctrl.dn) begin
      raddr_a = AW'(i_r + IW'(1));
      we      = v_r;
    end
    if (ctrl.span) begin
      raddr_a = i_r[AW-1:0];
      raddr_b = AW'(i_r + IW'(1) - kx);
    end
  end

  // sorted store, one write and two registered reads
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  // configuration and member count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r    <= WC_W'(1);
      count_r <= '0;
      v_r     <= 1'b0;
    end else begin
      if (cfg_we) wc_r <= cfg_window_count;
      if (stat.up_done) count_r <= count_r + CW'(1);
      if (stat.dn_done) count_r <= count_r - CW'(1);
      if (ctrl.load || ctrl.span_init) begin
        v_r <= 1'b0;
      end else if (ctrl.srch) begin
        v_r <= !stat.srch_done;
      end else if (ctrl.up) begin
        v_r <= more_up;
      end else if (ctrl.dn) begin
        v_r <= more_dn;
      end else if (ctrl.span) begin
        v_r <= more_span;
      end
    end
  end

  // walking index, pending tag and item payload
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key_r <= in_value ^ SIGN_BIAS;
      cmd_r <= in_command;
      i_r   <= '0;
    end
    if (ctrl.srch) begin
      if (stat.srch_done) begin
        pos_r <= CW'(pos_c);
        i_r   <= stat.need_up ? cnt_x : pos_c;
        if (cmd_r == CMD_INSERT) status_r <= (!present_c && full_c) ? ST_FULL : ST_OK;
        else status_r <= present_c ? ST_OK : ST_ABSENT;
      end else begin
        q_r <= i_r;
        i_r <= i_r + IW'(1);
      end
    end
    if (ctrl.up && more_up) begin
      q_r <= i_r;
      i_r <= i_r - IW'(1);
    end
    if (ctrl.dn && more_dn) begin
      q_r <= i_r;
      i_r <= i_r + IW'(1);
    end
    if (ctrl.span_init) begin
      i_r     <= kx - IW'(1);
      span_r  <= '1;
      found_r <= (cnt_x >= kx);
    end
    if (ctrl.span) begin
      if (v_r && (diff < span_r)) span_r <= diff;
      if (more_span) i_r <= i_r + IW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_span         <= found_r ? span_r : '0;
      out_found        <= found_r;
      out_status       <= status_r;
      out_stored_count <= CNT_OUT_W'(count_r);
    end
  end

endmodule
`default_nettype wire
